// ===== src/hpq_pkg.sv =====
package hpq_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int OCC_W = 7;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_RD    = 8'b0000_0010,
    S_UP_CMP   = 8'b0000_0100,
    S_DN_ROOT  = 8'b0000_1000,
    S_DN_LAST  = 8'b0001_0000,
    S_DN_RD    = 8'b0010_0000,
    S_DN_LEFT  = 8'b0100_0000,
    S_DN_RIGHT = 8'b1000_0000
  } state_t;

endpackage

// ===== src/hpq_ram.sv =====
module hpq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  hpq_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output hpq_pkg::entry_t rd_data
);
  import hpq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/max_heap_priority_queue_core.sv =====
// Binary max-heap priority queue. Pulse start while busy is low to issue an
// insert (in_action 0) or an extract of the largest-priority entry
// (in_action 1). The result is shown for exactly one cycle with out_valid,
// in the same cycle that busy falls, and the receiver cannot stall it. Entries
// live in a RAM with registered read data. One sequencer walks the heap one
// level at a time:
//   - an insert reads and compares one parent per level climbed;
//   - an extract reads the root and the last entry, then one or two
//     children per level descended when entries remain.
// So log2(CAPACITY) levels bound how long busy stays high. Errors
// (extract while empty, insert while full) never raise busy and report
// in the next cycle.
// A new item can start in the cycle its predecessor's result is shown.
// Priority ties keep the parent in place.
module max_heap_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_priority,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic signed [31:0] out_priority,
  output logic [1:0]         out_status,
  output logic [6:0]         out_occupancy
);
  import hpq_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  entry_t            key_r, key_nxt;
  entry_t            best_r, best_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic signed [31:0] out_prio_r, out_prio_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [6:0]         out_occ_r, out_occ_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;

  logic [IW-1:0] parent_idx;
  logic [XW-1:0] left_idx, right_idx, count_x;
  entry_t        cand;
  logic [IW-1:0] cand_idx;

  hpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign parent_idx = (pos_r - IW'(1)) >> 1;
  assign left_idx   = XW'({pos_r, 1'b1});
  assign right_idx  = left_idx + XW'(1);
  assign count_x    = XW'(count_r);

  // larger child; left wins ties
  always_comb begin
    if ((state_r == S_DN_RIGHT) && (rd_data.prio > best_r.prio)) begin
      cand     = rd_data;
      cand_idx = right_idx[IW-1:0];
    end else if (state_r == S_DN_RIGHT) begin
      cand     = best_r;
      cand_idx = best_idx_r;
    end else begin
      cand     = rd_data;
      cand_idx = left_idx[IW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_prio_nxt   = out_prio_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = key_r;
    rd_en          = 1'b0;
    rd_addr        = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_action == ACT_INSERT) begin
            if (count_r == CAP_C) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_prio_nxt   = '0;
              out_status_nxt = ST_FULL;
              out_occ_nxt    = OCC_W'(count_r);
            end else begin
              key_nxt.value = in_item_value;
              key_nxt.prio  = in_item_priority;
              pos_nxt       = count_r[IW-1:0];
              count_nxt     = count_r + CW'(1);
              state_nxt     = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = '0;
              out_prio_nxt   = '0;
              out_status_nxt = ST_EMPTY;
              out_occ_nxt    = OCC_W'(count_r);
            end else begin
              count_nxt = count_r - CW'(1);
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = S_DN_ROOT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_prio_nxt   = '0;
          out_status_nxt = ST_OK;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent_idx;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (key_r.prio > rd_data.prio) begin
          wr_en     = 1'b1;
          wr_data   = rd_data;
          pos_nxt   = parent_idx;
          state_nxt = S_UP_RD;
        end else begin
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_value_nxt  = '0;
          out_prio_nxt   = '0;
          out_status_nxt = ST_OK;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      S_DN_ROOT: begin
        out_value_nxt = rd_data.value;
        out_prio_nxt  = rd_data.prio;
        // count_r already points past the new end: it indexes the last entry
        rd_en         = 1'b1;
        rd_addr       = count_r[IW-1:0];
        state_nxt     = S_DN_LAST;
      end

      S_DN_LAST: begin
        key_nxt = rd_data;
        pos_nxt = '0;
        if (count_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end

      S_DN_RD: begin
        if (left_idx >= count_x) begin
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = left_idx[IW-1:0];
          state_nxt = S_DN_LEFT;
        end
      end

      S_DN_LEFT, S_DN_RIGHT: begin
        if ((state_r == S_DN_LEFT) && (right_idx < count_x)) begin
          best_nxt     = rd_data;
          best_idx_nxt = left_idx[IW-1:0];
          rd_en        = 1'b1;
          rd_addr      = right_idx[IW-1:0];
          state_nxt    = S_DN_RIGHT;
        end else if (key_r.prio < cand.prio) begin
          wr_en     = 1'b1;
          wr_data   = cand;
          pos_nxt   = cand_idx;
          state_nxt = S_DN_RD;
        end else begin
          wr_en          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    out_value_r  <= out_value_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_priority  = out_prio_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule
